>>> sv/kbd_pkg.sv
// shared types and constants for the key debounce and long/short press block
// used by every module of the block; depends on nothing
package kbd_pkg;

  // key count and fixed field widths
  localparam int NUM_KEYS_DEF = 2;
  localparam int KEY_IN_W     = 2;
  localparam int THRESH_W     = 16;
  localparam int STEP_W       = 8;
  localparam int MASK_W       = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 2;

  // register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = 16'd1000;
  localparam logic [STEP_W-1:0]   STEP_RST   = 8'd10;
  localparam logic [MASK_W-1:0]   MASK_RST   = 2'd2;

  // debounce settle count at which settling ends and key updates resume
  localparam logic [1:0] SETTLE_DONE = 2'd2;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_HOLD_STEP  = 2'd1,
    CFG_SHORT_MASK = 2'd2
  } cfg_idx_t;

  // input item: one scan tick
  typedef struct packed {
    logic [KEY_IN_W-1:0] key_levels;
    logic                transfer_locked;
  } in_item_t;

  // result item: events and beeps of one scan
  typedef struct packed {
    logic [1:0] long_event_mask;
    logic [1:0] short_event_mask;
    logic [1:0] long_beeps;
    logic [1:0] short_beeps;
  } out_item_t;

  // what one key lane found this scan
  typedef struct packed {
    logic long_hit;
    logic short_hit;
  } lane_evt_t;

endpackage

>>> sv/key_debounce_long_short_press.sv
// top level of the key debounce and long/short press detector
// depends on kbd_pkg, kbd_lane and kbd_merge
//
// Usage:
//   Input channel (in_valid/in_stall/in_data): one item per scan tick carrying
//   the raw level of each key (0 pressed) and the transfer-lock flag.
//   Output channel (out_valid/out_stall/out_data): exactly one result item per
//   input item with long/short event masks and long/short beep counts.
//   Configuration: cfg_we/cfg_index/cfg_data write the long press threshold,
//   the hold step and the short event enable mask; write only while idle.
//   Latency: the result item is valid the cycle after its input is accepted.
//   Throughput: one item per cycle while no result is stalled; every key has
//   its own lane whose update (one saturating add and one compare) completes
//   in the accept cycle; a single output register holds the merged result.
//   Stall: while a result waits with out_stall high, in_stall is high; the
//   moment the result is taken a new item can be taken in the same cycle.
//   Reset: rst (synchronous) restores register defaults, marks every key
//   released with zero hold count, and empties the output register.
module key_debounce_long_short_press #(
  parameter int NUM_KEYS = kbd_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  kbd_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output kbd_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [kbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kbd_pkg::*;

  logic [THRESH_W-1:0] long_press_threshold;
  logic [STEP_W-1:0]   hold_step;
  logic [MASK_W-1:0]   short_enable_mask;
  logic                accept;
  lane_evt_t           lane_evt [NUM_KEYS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_threshold <= THRESH_RST;
      hold_step            <= STEP_RST;
      short_enable_mask    <= MASK_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:  long_press_threshold <= cfg_data[THRESH_W-1:0];
        CFG_HOLD_STEP:  hold_step            <= cfg_data[STEP_W-1:0];
        CFG_SHORT_MASK: short_enable_mask    <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // take an item whenever the output register is free or being emptied
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // one lane per key; keys past the input width read as pressed
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic lvl;
    logic sen;
    if (k < KEY_IN_W) begin : g_vis
      assign lvl = in_data.key_levels[k];
      assign sen = short_enable_mask[k];
    end else begin : g_hid
      assign lvl = 1'b0;
      assign sen = 1'b0;
    end
    kbd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .level     (lvl),
      .locked    (in_data.transfer_locked),
      .short_en  (sen),
      .threshold (long_press_threshold),
      .step      (hold_step),
      .evt       (lane_evt[k])
    );
  end

  // merge lanes into the result item
  kbd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .lane_evt  (lane_evt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sv/kbd_lane.sv
// one key lane: debounce, saturating hold count and long/short press decision
// depends on kbd_pkg
module kbd_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          level,
  input  logic                          locked,
  input  logic                          short_en,
  input  logic [kbd_pkg::THRESH_W-1:0]  threshold,
  input  logic [kbd_pkg::STEP_W-1:0]    step,
  output kbd_pkg::lane_evt_t            evt
);
  import kbd_pkg::*;

  logic                confirmed, confirmed_next;
  logic [THRESH_W-1:0] hold_count, hold_count_next;
  logic                long_done, long_done_next;
  logic                settling, settling_next;
  logic [1:0]          settle_count, settle_count_next;

  logic [1:0]          settle_inc;
  logic                go;
  logic [THRESH_W:0]   sum;
  logic [THRESH_W-1:0] sat;

  // saturating add of the hold step
  assign sum = {1'b0, hold_count} + {{(THRESH_W + 1 - STEP_W){1'b0}}, step};
  assign sat = sum[THRESH_W] ? {THRESH_W{1'b1}} : sum[THRESH_W-1:0];
  assign settle_inc = settle_count + 2'd1;

  // per-scan key update
  always_comb begin
    confirmed_next    = confirmed;
    hold_count_next   = hold_count;
    long_done_next    = long_done;
    settling_next     = settling;
    settle_count_next = settle_count;
    evt               = '0;
    go                = 1'b0;
    if (level != confirmed) begin
      // level change: start debounce, nothing else this scan
      settling_next     = 1'b1;
      settle_count_next = 2'd1;
      confirmed_next    = level;
    end else begin
      go = 1'b1;
      if (settling) begin
        settle_count_next = settle_inc;
        if (settle_inc < SETTLE_DONE) begin
          go = 1'b0;
        end else begin
          settling_next = 1'b0;
        end
      end
      if (go) begin
        if (!level) begin
          // pressed: grow count, fire long once
          hold_count_next = sat;
          if (sat >= threshold && !long_done) begin
            long_done_next = 1'b1;
            evt.long_hit   = !locked;
          end
        end else begin
          // released: short press if no long fired
          if (hold_count != '0 && !long_done) begin
            evt.short_hit = short_en && !locked;
          end
          hold_count_next = '0;
          long_done_next  = 1'b0;
        end
      end
    end
  end

  // key state, updated once per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      confirmed    <= 1'b1;
      hold_count   <= '0;
      long_done    <= 1'b0;
      settling     <= 1'b0;
      settle_count <= '0;
    end else if (accept) begin
      confirmed    <= confirmed_next;
      hold_count   <= hold_count_next;
      long_done    <= long_done_next;
      settling     <= settling_next;
      settle_count <= settle_count_next;
    end
  end

endmodule

>>> sv/kbd_merge.sv
// merge stage: combines lane events into masks and beep counts, holds the result item
// depends on kbd_pkg
module kbd_merge #(
  parameter int NUM_KEYS = kbd_pkg::NUM_KEYS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  kbd_pkg::lane_evt_t            lane_evt [NUM_KEYS],
  input  logic                          out_stall,
  output logic                          out_valid,
  output kbd_pkg::out_item_t            out_data
);
  import kbd_pkg::*;

  localparam int CNT_RAW = $clog2(NUM_KEYS + 1);
  localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;
  localparam int MASK_KEYS = (NUM_KEYS < 2) ? NUM_KEYS : 2;

  logic [CNT_W-1:0] long_cnt, short_cnt;
  logic [1:0]       long_mask, short_mask;
  out_item_t        item_next;
  logic             out_valid_next;

  // count beeps over all lanes, masks cover the two visible keys
  always_comb begin
    long_cnt   = '0;
    short_cnt  = '0;
    long_mask  = '0;
    short_mask = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      long_cnt  = long_cnt + CNT_W'(lane_evt[k].long_hit);
      short_cnt = short_cnt + CNT_W'(lane_evt[k].short_hit);
    end
    for (int k = 0; k < MASK_KEYS; k++) begin
      long_mask[k]  = lane_evt[k].long_hit;
      short_mask[k] = lane_evt[k].short_hit;
    end
    item_next.long_event_mask  = long_mask;
    item_next.short_event_mask = short_mask;
    item_next.long_beeps       = long_cnt[1:0];
    item_next.short_beeps      = short_cnt[1:0];
  end

  // output register valid
  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload, loaded when an item is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= item_next;
    end
  end

endmodule

>>> sv/kbd_checker.sv
// port-level checks for the key debounce and long/short press block, with its bind
// depends on kbd_pkg and key_debounce_long_short_press
module kbd_checker #(
  parameter int NUM_KEYS = kbd_pkg::NUM_KEYS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input kbd_pkg::out_item_t out_data
);
  import kbd_pkg::*;

  // a waiting result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result item valid right after reset");

  // a key cannot report long and short in the same scan
  a_disjoint: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.long_event_mask & out_data.short_event_mask) == 2'b00)
    else $error("key reported long and short press together");

  // short beeps match the short event mask
  a_short_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones(out_data.short_event_mask) == int'(out_data.short_beeps))
    else $error("short beep count does not match short events");

  // with only the visible keys, long beeps match the long event mask
  a_long_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (NUM_KEYS <= KEY_IN_W) |->
      $countones(out_data.long_event_mask) == int'(out_data.long_beeps))
    else $error("long beep count does not match long events");

endmodule

bind key_debounce_long_short_press kbd_checker #(.NUM_KEYS(NUM_KEYS)) u_kbd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
